// ===== hdl/rv32x_pkg.sv =====
package rv32x_pkg;

  // Register file geometry
  localparam int unsigned XLEN       = 32;
  localparam int unsigned RegCount   = 32;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned UpperShift = 12;

  // Stream widths (bits used, then padded to bytes)
  localparam int unsigned InBits   = 6 + 3 * RegIdxW + 3 * XLEN;
  localparam int unsigned InBytesW = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = XLEN + 1 + RegIdxW + 2 + 2 * XLEN + 1;
  localparam int unsigned OutBytesW = ((OutBits + 7) / 8) * 8;

  // Instruction kinds
  typedef enum logic [5:0] {
    KAdd = 6'd0, KSub = 6'd1, KMul = 6'd2, KDiv = 6'd3, KSll = 6'd4, KMulh = 6'd5,
    KSlt = 6'd6, KMulhsu = 6'd7, KSltu = 6'd8, KMulhu = 6'd9, KXor = 6'd10,
    KDivu = 6'd11, KSrl = 6'd12, KSra = 6'd13, KOr = 6'd14, KRem = 6'd15,
    KAnd = 6'd16, KRemu = 6'd17,
    KAddi = 6'd18, KSubi = 6'd19, KMuli = 6'd20, KDivi = 6'd21, KSlli = 6'd22,
    KSlti = 6'd23, KSltiu = 6'd24, KXori = 6'd25, KOri = 6'd26, KAndi = 6'd27,
    KLoad = 6'd28, KStore = 6'd29, KJal = 6'd30, KHalt = 6'd31, KLui = 6'd32,
    KAuipc = 6'd33, KLoadRet = 6'd34
  } kind_e;

  // Memory access codes
  typedef enum logic [1:0] {
    AccNone = 2'd0, AccLoad = 2'd1, AccStore = 2'd2, AccJump = 2'd3
  } access_e;

  // Multiply/divide unit operations
  typedef enum logic [2:0] {
    MdMul = 3'd0, MdMulh = 3'd1, MdMulhsu = 3'd2, MdMulhu = 3'd3,
    MdDiv = 3'd4, MdDivu = 3'd5, MdRem = 3'd6, MdRemu = 3'd7
  } md_op_e;

  typedef struct packed {
    logic           start;
    md_op_e         op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] result;
  } md_rsp_t;

  // Immediate kinds map onto the register ALU codes
  function automatic kind_e imm_to_alu(input kind_e k);
    kind_e r;
    unique case (k)
      KAddi:   r = KAdd;
      KSubi:   r = KSub;
      KMuli:   r = KMul;
      KDivi:   r = KDiv;
      KSlli:   r = KSll;
      KSlti:   r = KSlt;
      KSltiu:  r = KSltu;
      KXori:   r = KXor;
      KOri:    r = KOr;
      KAndi:   r = KAnd;
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/rv32x_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rv32x_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/rv32x_muldiv.sv =====
// Multiply (one registered stage) and radix-2 restoring divide (32 steps)
module rv32x_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rv32x_pkg::md_req_t req_i,
  output rv32x_pkg::md_rsp_t rsp_o
);

  localparam int unsigned W = rv32x_pkg::XLEN;

  logic                  busy_q, mul_pend_q, done_q;
  logic [4:0]            cnt_q;
  rv32x_pkg::md_op_e     op_q;
  logic signed [2*W+1:0] prod_q;
  logic [W-1:0]          rem_q, quo_q, dvs_q;
  logic                  neg_q_q, neg_r_q, bzero_q;

  logic                  is_div, a_sgn, b_sgn, a_neg, b_neg;
  logic signed [W:0]     a_ext, b_ext;
  logic [W-1:0]          a_mag, b_mag;
  logic [W:0]            shifted;
  logic [W+1:0]          diff;

  // Operand preparation
  always_comb begin
    is_div = req_i.op[2];
    a_sgn  = (req_i.op == rv32x_pkg::MdMulh) || (req_i.op == rv32x_pkg::MdMulhsu) ||
             (req_i.op == rv32x_pkg::MdDiv) || (req_i.op == rv32x_pkg::MdRem);
    b_sgn  = (req_i.op == rv32x_pkg::MdMulh) || (req_i.op == rv32x_pkg::MdDiv) ||
             (req_i.op == rv32x_pkg::MdRem);
    a_ext  = {a_sgn & req_i.a[W-1], req_i.a};
    b_ext  = {b_sgn & req_i.b[W-1], req_i.b};
    a_neg  = a_sgn & req_i.a[W-1];
    b_neg  = b_sgn & req_i.b[W-1];
    a_mag  = a_neg ? (W'(0) - req_i.a) : req_i.a;
    b_mag  = b_neg ? (W'(0) - req_i.b) : req_i.b;
  end

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      mul_pend_q <= 1'b0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (req_i.start) begin
      busy_q     <= is_div;
      mul_pend_q <= !is_div;
      done_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (mul_pend_q) begin
      mul_pend_q <= 1'b0;
      done_q     <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q    <= req_i.op;
      prod_q  <= a_ext * b_ext;
      rem_q   <= '0;
      quo_q   <= a_mag;
      dvs_q   <= b_mag;
      neg_q_q <= a_neg ^ b_neg;
      neg_r_q <= a_neg;
      bzero_q <= (req_i.b == '0);
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], !diff[W+1]};
      rem_q <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
    end
  end

  // Result selection
  always_comb begin
    rsp_o.done = done_q;
    unique case (op_q)
      rv32x_pkg::MdMul:    rsp_o.result = prod_q[W-1:0];
      rv32x_pkg::MdMulh,
      rv32x_pkg::MdMulhsu,
      rv32x_pkg::MdMulhu:  rsp_o.result = prod_q[2*W-1:W];
      rv32x_pkg::MdDiv:    rsp_o.result = bzero_q ? '1 :
                                          (neg_q_q ? (W'(0) - quo_q) : quo_q);
      rv32x_pkg::MdDivu:   rsp_o.result = quo_q;
      rv32x_pkg::MdRem:    rsp_o.result = neg_r_q ? (W'(0) - rem_q) : rem_q;
      rv32x_pkg::MdRemu:   rsp_o.result = rem_q;
      default:             rsp_o.result = '0;
    endcase
  end

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> !done_q)
    else $error("muldiv done not cleared by start");
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && mul_pend_q))
    else $error("muldiv multiply and divide active together");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd31 && !req_i.start) |=> done_q)
    else $error("divide did not finish after 32 steps");

endmodule

// ===== hdl/rv32im_execute_with_register_file.sv =====
// Channel   Dir  Bits  Contents
// s_axis    in   120   one decoded instruction request
// m_axis    out  112   one result request per instruction
//
// ALU, load/store, jump, upper-immediate and load-return read the register
// file, then compute and write back. Multiplies start the unit, take the
// registered product, then write back; divide and remainder produce one
// quotient bit per cycle in the shared divide unit. Reset clears the per-
// register valid bits at once, so the file reads as zero with no sweep. A
// result waiting in the output register does not block the next request;
// a finished result stalls only while that register is still full.
module rv32im_execute_with_register_file (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[5:0], dest_index[10:6], src_a_index[15:11], src_b_index[20:16],
  // imm_value[52:21], instr_pc[84:53], load_data[116:85], zero pad
  input  logic [119:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // value[31:0], write_enable[32], write_index[37:33], access_kind[39:38],
  // address[71:40], store_data[103:72], halt[104], zero pad
  output logic [111:0] m_axis_tdata_o
);

  localparam int unsigned W  = rv32x_pkg::XLEN;
  localparam int unsigned IW = rv32x_pkg::RegIdxW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StWait = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Captured request
  rv32x_pkg::kind_e kind_q;
  logic [IW-1:0]    dst_q, sa_q, sb_q;
  logic [W-1:0]     imm_q, pc_q, ld_q;

  logic [rv32x_pkg::RegCount-1:0] valid_q;
  logic [W-1:0]     rd_a, rd_b, op_a, op_b;
  logic             accept, finish, out_free, md_start, is_md, wants_write, wrote;
  rv32x_pkg::kind_e eff_op;
  rv32x_pkg::md_op_e md_op;
  rv32x_pkg::access_e access;
  logic [W-1:0]     alu_val, value, address, sdata;
  logic             halt;
  rv32x_pkg::md_req_t md_req;
  rv32x_pkg::md_rsp_t md_rsp;

  logic                 out_valid_q;
  logic [111:0]         out_data_q;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Register file, duplicated for two read ports; hold the captured
  // addresses while a request is in flight
  rv32x_ram #(.Width(W), .Depth(rv32x_pkg::RegCount)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wrote && finish),
    .waddr_i (dst_q),
    .wdata_i (value),
    .raddr_i (s_axis_tready_o ? s_axis_tdata_i[15:11] : sa_q),
    .rdata_o (rd_a)
  );

  rv32x_ram #(.Width(W), .Depth(rv32x_pkg::RegCount)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wrote && finish),
    .waddr_i (dst_q),
    .wdata_i (value),
    .raddr_i (s_axis_tready_o ? s_axis_tdata_i[20:16] : sb_q),
    .rdata_o (rd_b)
  );

  // Unwritten or zero registers read as zero
  always_comb begin
    op_a = (valid_q[sa_q] && sa_q != '0) ? rd_a : '0;
    op_b = (valid_q[sb_q] && sb_q != '0) ? rd_b : '0;
  end

  // Decode
  always_comb begin
    eff_op = rv32x_pkg::imm_to_alu(kind_q);
    is_md  = 1'b0;
    md_op  = rv32x_pkg::MdMul;
    unique case (eff_op)
      rv32x_pkg::KMul:    begin is_md = 1'b1; md_op = rv32x_pkg::MdMul;    end
      rv32x_pkg::KMulh:   begin is_md = 1'b1; md_op = rv32x_pkg::MdMulh;   end
      rv32x_pkg::KMulhsu: begin is_md = 1'b1; md_op = rv32x_pkg::MdMulhsu; end
      rv32x_pkg::KMulhu:  begin is_md = 1'b1; md_op = rv32x_pkg::MdMulhu;  end
      rv32x_pkg::KDiv:    begin is_md = 1'b1; md_op = rv32x_pkg::MdDiv;    end
      rv32x_pkg::KDivu:   begin is_md = 1'b1; md_op = rv32x_pkg::MdDivu;   end
      rv32x_pkg::KRem:    begin is_md = 1'b1; md_op = rv32x_pkg::MdRem;    end
      rv32x_pkg::KRemu:   begin is_md = 1'b1; md_op = rv32x_pkg::MdRemu;   end
      default:            ;
    endcase
  end

  assign md_req.start = md_start;
  assign md_req.op    = md_op;
  assign md_req.a     = op_a;
  assign md_req.b     = (kind_q <= rv32x_pkg::KRemu) ? op_b : imm_q;

  rv32x_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Simple ALU
  always_comb begin
    unique case (eff_op)
      rv32x_pkg::KAdd:  alu_val = op_a + md_req.b;
      rv32x_pkg::KSub:  alu_val = op_a - md_req.b;
      rv32x_pkg::KSll:  alu_val = op_a << md_req.b[4:0];
      rv32x_pkg::KSlt:  alu_val = W'($signed(op_a) < $signed(md_req.b));
      rv32x_pkg::KSltu: alu_val = W'(op_a < md_req.b);
      rv32x_pkg::KXor:  alu_val = op_a ^ md_req.b;
      rv32x_pkg::KSrl:  alu_val = op_a >> md_req.b[4:0];
      rv32x_pkg::KSra:  alu_val = W'($signed(op_a) >>> md_req.b[4:0]);
      rv32x_pkg::KOr:   alu_val = op_a | md_req.b;
      rv32x_pkg::KAnd:  alu_val = op_a & md_req.b;
      default:          alu_val = '0;
    endcase
  end

  // Result fields
  always_comb begin
    value       = '0;
    address     = '0;
    sdata       = '0;
    access      = rv32x_pkg::AccNone;
    halt        = 1'b0;
    wants_write = 1'b0;
    priority if (kind_q <= rv32x_pkg::KAndi) begin
      value       = is_md ? md_rsp.result : alu_val;
      wants_write = 1'b1;
    end else begin
      unique case (kind_q)
        rv32x_pkg::KLoad: begin
          access  = rv32x_pkg::AccLoad;
          address = op_a + imm_q;
        end
        rv32x_pkg::KStore: begin
          access  = rv32x_pkg::AccStore;
          address = op_a + imm_q;
          sdata   = op_b;
        end
        rv32x_pkg::KJal: begin
          access      = rv32x_pkg::AccJump;
          address     = pc_q + imm_q;
          value       = pc_q + W'(4);
          wants_write = 1'b1;
        end
        rv32x_pkg::KHalt:  halt = 1'b1;
        rv32x_pkg::KLui: begin
          value       = imm_q << rv32x_pkg::UpperShift;
          wants_write = 1'b1;
        end
        rv32x_pkg::KAuipc: begin
          value       = pc_q + (imm_q << rv32x_pkg::UpperShift);
          wants_write = 1'b1;
        end
        rv32x_pkg::KLoadRet: begin
          value       = ld_q;
          wants_write = 1'b1;
        end
        default: ;
      endcase
    end
    wrote = wants_write && (dst_q != '0) &&
            ({1'b0, dst_q} < (IW+1)'(rv32x_pkg::RegCount));
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    finish   = 1'b0;
    md_start = 1'b0;
    unique case (state_q)
      StIdle: if (accept) state_d = StExec;
      StExec: begin
        if (is_md) begin
          md_start = 1'b1;
          state_d  = StWait;
        end else if (out_free) begin
          finish  = 1'b1;
          state_d = StIdle;
        end
      end
      StWait: if (md_rsp.done && out_free) begin
        finish  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish && wrote) begin
        valid_q[dst_q] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= rv32x_pkg::kind_e'(s_axis_tdata_i[5:0]);
      dst_q  <= s_axis_tdata_i[10:6];
      sa_q   <= s_axis_tdata_i[15:11];
      sb_q   <= s_axis_tdata_i[20:16];
      imm_q  <= s_axis_tdata_i[52:21];
      pc_q   <= s_axis_tdata_i[84:53];
      ld_q   <= s_axis_tdata_i[116:85];
    end
    if (finish) begin
      out_data_q <= {7'd0, halt, sdata, address, access,
                     wrote ? dst_q : {IW{1'b0}}, wrote, value};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
  a_x0_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0])
    else $error("register zero marked written");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == StIdle) && out_valid_q)
    else $error("finished request not presented");
  a_start_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_start |-> (state_q == StExec) && !finish)
    else $error("muldiv started outside execute");

endmodule

// ===== test/rv32im_execute_with_register_file_tb.sv =====
`timescale 1ns / 1ps

module rv32im_execute_with_register_file_tb;

  typedef struct packed {
    logic [5:0]  kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] ld;
  } instr_t;

  // packed from the highest bit down, so value lands in the low bits
  typedef struct packed {
    logic        halt;
    logic [31:0] sdata;
    logic [31:0] addr;
    logic [1:0]  acc;
    logic [4:0]  widx;
    logic        we;
    logic [31:0] value;
  } wb_t;

  localparam int unsigned NumRandom = 1330;
  localparam int unsigned WatchLimit = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [119:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;

  rv32im_execute_with_register_file i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  // shadow register file and pending writebacks
  logic [31:0] shadow_regs [rv32x_pkg::RegCount];
  wb_t         pending_wb [$];
  int          error_count = 0;
  int          sent_count = 0;
  int          got_count = 0;
  bit          hold_off = 1'b0;
  bit          no_idle = 1'b0;
  bit          stim_done = 1'b0;

  function automatic logic [31:0] read_reg(logic [4:0] idx);
    if (idx == 0 || idx >= rv32x_pkg::RegCount) return '0;
    return shadow_regs[idx];
  endfunction

  function automatic logic [31:0] alu_eval(rv32x_pkg::kind_e op, logic [31:0] a,
                                           logic [31:0] b);
    logic [63:0] p;
    logic [31:0] ua, ub, q;
    case (op)
      rv32x_pkg::KAdd: return a + b;
      rv32x_pkg::KSub: return a - b;
      rv32x_pkg::KMul: return a * b;
      rv32x_pkg::KDiv, rv32x_pkg::KRem: begin
        if (b == 0) return (op == rv32x_pkg::KDiv) ? 32'hFFFF_FFFF : a;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        if (op == rv32x_pkg::KDiv) begin
          q = ua / ub;
          return (a[31] ^ b[31]) ? -q : q;
        end
        q = ua % ub;
        return a[31] ? -q : q;
      end
      rv32x_pkg::KSll: return a << b[4:0];
      rv32x_pkg::KMulh: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return p[63:32];
      end
      rv32x_pkg::KSlt: return {31'd0, $signed(a) < $signed(b)};
      rv32x_pkg::KMulhsu: begin
        p = {{32{a[31]}}, a} * {32'd0, b};
        return p[63:32];
      end
      rv32x_pkg::KSltu: return {31'd0, a < b};
      rv32x_pkg::KMulhu: begin
        p = {32'd0, a} * {32'd0, b};
        return p[63:32];
      end
      rv32x_pkg::KXor: return a ^ b;
      rv32x_pkg::KDivu: return (b == 0) ? 32'hFFFF_FFFF : a / b;
      rv32x_pkg::KSrl: return a >> b[4:0];
      rv32x_pkg::KSra: return $unsigned($signed(a) >>> b[4:0]);
      rv32x_pkg::KOr: return a | b;
      rv32x_pkg::KAnd: return a & b;
      rv32x_pkg::KRemu: return (b == 0) ? a : a % b;
      default: return '0;
    endcase
  endfunction

  // executes one instruction on the shadow file and returns its writeback
  function automatic wb_t predict_step(instr_t ins);
    wb_t r;
    logic [31:0] a, b;
    logic        wants;
    rv32x_pkg::kind_e k;
    r = '0;
    wants = 1'b0;
    a = read_reg(ins.rs1);
    b = read_reg(ins.rs2);
    k = rv32x_pkg::kind_e'(ins.kind);
    if (ins.kind <= rv32x_pkg::KRemu) begin
      r.value = alu_eval(k, a, b);
      wants = 1'b1;
    end else if (ins.kind <= rv32x_pkg::KAndi) begin
      r.value = alu_eval(rv32x_pkg::imm_to_alu(k), a, ins.imm);
      wants = 1'b1;
    end else if (ins.kind == rv32x_pkg::KLoad) begin
      r.acc = rv32x_pkg::AccLoad;
      r.addr = a + ins.imm;
    end else if (ins.kind == rv32x_pkg::KStore) begin
      r.acc = rv32x_pkg::AccStore;
      r.addr = a + ins.imm;
      r.sdata = b;
    end else if (ins.kind == rv32x_pkg::KJal) begin
      r.acc = rv32x_pkg::AccJump;
      r.addr = ins.pc + ins.imm;
      r.value = ins.pc + 32'd4;
      wants = 1'b1;
    end else if (ins.kind == rv32x_pkg::KHalt) begin
      r.halt = 1'b1;
    end else if (ins.kind == rv32x_pkg::KLui) begin
      r.value = ins.imm << rv32x_pkg::UpperShift;
      wants = 1'b1;
    end else if (ins.kind == rv32x_pkg::KAuipc) begin
      r.value = ins.pc + (ins.imm << rv32x_pkg::UpperShift);
      wants = 1'b1;
    end else if (ins.kind == rv32x_pkg::KLoadRet) begin
      r.value = ins.ld;
      wants = 1'b1;
    end
    if (wants && ins.rd != 0 && ins.rd < rv32x_pkg::RegCount) begin
      shadow_regs[ins.rd] = r.value;
      r.we = 1'b1;
      r.widx = ins.rd;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch result %0d %s: got %h want %h", got_count, what, got, want);
    error_count++;
  endtask

  function automatic instr_t make_instr(int k, int rd, int rs1, int rs2,
                                        logic [31:0] imm, logic [31:0] pc,
                                        logic [31:0] ld);
    instr_t i;
    i.kind = 6'(k); i.rd = 5'(rd); i.rs1 = 5'(rs1); i.rs2 = 5'(rs2);
    i.imm = imm; i.pc = pc; i.ld = ld;
    return i;
  endfunction

  // random instruction: mostly valid kinds, small register pool for reuse
  function automatic instr_t random_instr();
    instr_t i;
    int     sel;
    logic [31:0] vals [6];
    logic [127:0] rnd;
    vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd31};
    rnd = {$urandom, $urandom, $urandom, $urandom};
    i = rnd[116:0];
    sel = $urandom_range(0, 99);
    if (sel < 3) i.kind = 6'($urandom_range(35, 63));
    else if (sel < 20) i.kind = rv32x_pkg::KLoadRet;
    else i.kind = 6'($urandom_range(0, 33));
    if ($urandom_range(0, 3) != 0) begin
      i.rs1 = 5'($urandom_range(0, 7));
      i.rs2 = 5'($urandom_range(0, 7));
      i.rd  = 5'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 3) == 0) i.imm = vals[$urandom_range(0, 5)];
    if ($urandom_range(0, 3) == 0) i.ld = vals[$urandom_range(0, 5)];
    return i;
  endfunction

  // directed table: fill registers with extremes, then exercise a selection of kinds
  instr_t dir_tab [$];
  wb_t    dir_want [$];
  bit     dir_known [$];

  task automatic add_row(instr_t i, bit known, wb_t w);
    dir_tab.push_back(i);
    dir_known.push_back(known);
    dir_want.push_back(w);
  endtask

  task automatic send_instr(instr_t ins);
    wb_t w;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {3'd0, ins.ld, ins.pc, ins.imm, ins.rs2, ins.rs1, ins.rd, ins.kind};
    do @(posedge clk_i); while (!s_axis_tready_o);
    w = predict_step(ins);
    pending_wb.push_back(w);
    sent_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    wb_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[104:0];
      if (pending_wb.size() == 0) begin
        $display("unexpected result %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_wb.pop_front();
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.we !== want.we)
          report_mismatch("write_enable", 32'(got.we), 32'(want.we));
        if (got.widx !== want.widx)
          report_mismatch("write_index", 32'(got.widx), 32'(want.widx));
        if (got.acc !== want.acc)
          report_mismatch("access_kind", 32'(got.acc), 32'(want.acc));
        if (got.addr !== want.addr) report_mismatch("address", got.addr, want.addr);
        if (got.sdata !== want.sdata) report_mismatch("store_data", got.sdata, want.sdata);
        if (got.halt !== want.halt)
          report_mismatch("halt", 32'(got.halt), 32'(want.halt));
      end
      got_count++;
    end
  end

  // receiver ready: random stalls, a forced long hold, none at the end
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else if (!no_idle && m_axis_tready_i && $urandom_range(0, 9) == 0) begin
      m_axis_tready_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit && (!stim_done || pending_wb.size() != 0)) begin
      $display("timeout with %0d results outstanding", pending_wb.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    wb_t    w;
    instr_t ins;
    for (int r = 0; r < rv32x_pkg::RegCount; r++) shadow_regs[r] = '0;

    // after reset every register reads zero
    w = '0; w.value = 32'd0; w.we = 1; w.widx = 1;
    add_row(make_instr(rv32x_pkg::KAdd, 1, 2, 3, 0, 0, 0), 1, w);
    w = '0; w.value = 32'h8000_0000; w.we = 1; w.widx = 1;
    add_row(make_instr(rv32x_pkg::KLoadRet, 1, 0, 0, 0, 0, 32'h8000_0000), 1, w);
    w = '0; w.value = 32'hFFFF_FFFF; w.we = 1; w.widx = 2;
    add_row(make_instr(rv32x_pkg::KLoadRet, 2, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, w);
    w = '0; w.value = 32'h7FFF_FFFF; w.we = 1; w.widx = 31;
    add_row(make_instr(rv32x_pkg::KLoadRet, 31, 0, 0, 0, 0, 32'h7FFF_FFFF), 1, w);
    // write to x0 dropped
    w = '0; w.value = 32'h1234_5678;
    add_row(make_instr(rv32x_pkg::KLoadRet, 0, 0, 0, 0, 0, 32'h1234_5678), 1, w);
    // divide by zero and overflow
    w = '0; w.value = 32'hFFFF_FFFF; w.we = 1; w.widx = 3;
    add_row(make_instr(rv32x_pkg::KDiv, 3, 1, 0, 0, 0, 0), 1, w);
    w = '0; w.value = 32'h8000_0000; w.we = 1; w.widx = 4;
    add_row(make_instr(rv32x_pkg::KRemu, 4, 1, 0, 0, 0, 0), 1, w);
    w = '0; w.value = 32'h8000_0000; w.we = 1; w.widx = 5;
    add_row(make_instr(rv32x_pkg::KDiv, 5, 1, 2, 0, 0, 0), 1, w);
    w = '0; w.we = 1; w.widx = 6;
    add_row(make_instr(rv32x_pkg::KRem, 6, 1, 2, 0, 0, 0), 1, w);
    w = '0; w.halt = 1;
    add_row(make_instr(rv32x_pkg::KHalt, 7, 1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1, w);
    w = '0;
    add_row(make_instr(63, 7, 1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, w);
    // further kinds, predicted
    add_row(make_instr(rv32x_pkg::KSra, 8, 1, 31, 0, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KSll, 9, 2, 31, 0, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KMulh, 10, 1, 1, 0, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KMulhsu, 10, 1, 2, 0, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KMulhu, 10, 2, 2, 0, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KSltiu, 11, 0, 0, 32'hFFFF_FFFF, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KDivi, 12, 1, 0, 32'hFFFF_FFFF, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KSlli, 13, 2, 0, 32'h0000_0FE3, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KLoad, 14, 31, 0, 32'd1, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KStore, 14, 1, 2, 32'hFFFF_FFFF, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KJal, 15, 0, 0, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KLui, 16, 0, 0, 32'h000F_FFFF, 0, 0), 0, w);
    add_row(make_instr(rv32x_pkg::KAuipc, 17, 0, 0, 32'h000F_FFFF, 32'hFFFF_F000, 0), 0, w);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the typed rows lead the table, so they run in order from reset here
    foreach (dir_tab[n]) begin
      if (dir_known[n]) begin
        ins = dir_tab[n];
        w = predict_step(ins);
        if (w !== dir_want[n]) begin
          $display("table row %0d disagrees with predictor", n);
          error_count++;
        end
      end
    end
    // rebuild shadow from reset then drive the table for real
    for (int r = 0; r < rv32x_pkg::RegCount; r++) shadow_regs[r] = '0;
    foreach (dir_tab[n]) send_instr(dir_tab[n]);

    // long receiver hold so the block backs up its input
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_instr(random_instr());
    join

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        // sender pause until everything drained
        s_axis_tvalid_i <= 1'b0;
        while (pending_wb.size() != 0) @(posedge clk_i);
      end
      if (n == NumRandom - 150) no_idle = 1'b1;
      send_instr(random_instr());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
    while (pending_wb.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d instructions covering all kinds, x0 and divide corner cases,",
             sent_count);
    $display("with random stalls on both sides; %0d results checked.", got_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
